>>> src/swm_pkg.sv
// Package for the spectral window multiplier: window codes, register indexes,
// Q30 window constants and the structs passed between the block's units.
// No dependencies.
`default_nettype none

package swm_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int WTYPE_W    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TYPE  = 2'd1;

    localparam logic [WTYPE_W-1:0] WIN_RECT     = 2'd0;
    localparam logic [WTYPE_W-1:0] WIN_HAMMING  = 2'd1;
    localparam logic [WTYPE_W-1:0] WIN_HANN     = 2'd2;
    localparam logic [WTYPE_W-1:0] WIN_BLACKMAN = 2'd3;

    localparam int RST_FRAME_LENGTH = 1024;

    // Q30 constants
    localparam logic [31:0] ONE_Q30 = 32'd1073741824;
    localparam logic [31:0] K_HAM_A = 32'd579820585;
    localparam logic [31:0] K_HAM_B = 32'd493921239;
    localparam logic [31:0] K_HALF  = 32'd536870912;
    localparam logic [31:0] K_BK_A  = 32'd450971566;
    localparam logic [31:0] K_BK_C  = 32'd85899346;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // cosine table entries are Q1.30 magnitudes in [0, 1.0]
    localparam int COS_W = 31;

    // phase step divider: 33 quotient bits, one per cycle
    localparam int DIV_STEPS = 33;
    localparam int DIV_CNT_W = 6;

    typedef struct packed {
        logic [31:0]        phase;
        logic [WTYPE_W-1:0] wtype;
        logic               unity;
    } coef_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

>>> src/swm_if.sv
// Stream interfaces of the spectral window multiplier: sample words in,
// weighted result words out. Valid/ready handshake. No dependencies.
`default_nettype none

interface swm_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface swm_result_if #(
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] windowed_sample;
    logic        [COEF_BITS-1:0]   coefficient;
    logic                          frame_end;

    modport source (output valid, output windowed_sample, output coefficient,
                    output frame_end, input ready);
    modport sink   (input valid, input windowed_sample, input coefficient,
                    input frame_end, output ready);
endinterface

`default_nettype wire

>>> src/swm_step_div.sv
// Restoring divider for the phase step round(2^32 / m), one quotient bit per cycle.
// Depends on swm_pkg.
`default_nettype none

module swm_step_div
    import swm_pkg::*;
#(
    parameter int DIV_W = 12
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  divisor,
    output div_status_t       status,
    output logic [31:0]       quotient
);

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_W-1:0]     dvsr_reg, dvsr_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [32:0]          work_reg, work_next;
    logic [DIV_W:0]       rem_sh;
    logic [DIV_W:0]       diff;
    logic                 ge;

    always_comb
    begin
        rem_sh    = {rem_reg, work_reg[32]};
        diff      = rem_sh - {1'b0, dvsr_reg};
        ge        = rem_sh >= {1'b0, dvsr_reg};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        dvsr_next = dvsr_reg;
        rem_next  = rem_reg;
        work_next = work_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            dvsr_next = divisor;
            rem_next  = '0;
            // dividend 2^32 + floor(m/2) rounds the quotient to nearest
            work_next = {1'b1, 32'(divisor >> 1)};
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            work_next = {work_reg[31:0], ge};
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvsr_reg <= dvsr_next;
        rem_reg  <= rem_next;
        work_reg <= work_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = work_reg[31:0];

endmodule

`default_nettype wire

>>> src/swm_coef_unit.sv
// Window coefficient unit: quarter-wave cosine ROM with two synchronous read
// ports, window constant products and clamp/round to Q1.(COEF_BITS-1). Depends on swm_pkg.
`default_nettype none

module swm_coef_unit
    import swm_pkg::*;
#(
    parameter int COEF_BITS       = 16,
    parameter int COS_TABLE_DEPTH = 1024
)
(
    input  logic                 clk,
    input  logic                 adv,
    input  coef_req_t            req,
    output logic [COEF_BITS-1:0] coef
);

    localparam int IW = $clog2(COS_TABLE_DEPTH + 1);
    localparam int MW = 30 + IW;
    localparam int TW = 34;

    typedef logic [COS_W-1:0] cos_tab_t [COS_TABLE_DEPTH+1];

    // quarter-wave cosine by a truncated thirteen-term Taylor series in Q30
    function automatic cos_tab_t build_cos_tab();
        cos_tab_t          tab;
        logic [63:0]       x;
        logic [63:0]       m;
        logic signed [63:0] acc;
        for (int i = 0; i <= COS_TABLE_DEPTH; i++)
        begin
            x   = (64'(i) * HALF_PI_Q30 + 64'(COS_TABLE_DEPTH / 2)) / 64'(COS_TABLE_DEPTH);
            m   = 64'(ONE_Q30);
            acc = $signed(64'(ONE_Q30));
            for (int k = 1; k <= 12; k++)
            begin
                m = (m * x) >> 30;
                m = (m * x) >> 30;
                m = m / 64'((2 * k - 1) * (2 * k));
                if (k % 2 == 1)
                    acc = acc - $signed(m);
                else
                    acc = acc + $signed(m);
            end
            if (acc < 0)
                acc = '0;
            if (acc > $signed(64'(ONE_Q30)))
                acc = $signed(64'(ONE_Q30));
            tab[i] = acc[COS_W-1:0];
        end
        return tab;
    endfunction

    localparam cos_tab_t COS_TAB = build_cos_tab();

    function automatic logic [IW-1:0] cos_addr(input logic [31:0] ph);
        logic [MW-1:0] scaled;
        logic [IW-1:0] idx;
        scaled = MW'(ph[29:0]) * MW'(COS_TABLE_DEPTH) + (MW'(1) << 29);
        idx    = scaled[30 +: IW];
        if (idx > IW'(COS_TABLE_DEPTH))
            idx = IW'(COS_TABLE_DEPTH);
        return ph[30] ? IW'(COS_TABLE_DEPTH) - idx : idx;
    endfunction

    logic [31:0]        phase2;
    logic [IW-1:0]      addr_a, addr_b;

    logic [COS_W-1:0]   cos_a_reg, cos_b_reg;
    logic               neg_a_reg, neg_b_reg;
    logic [WTYPE_W-1:0] wtype1_reg, wtype2_reg;
    logic               unity1_reg, unity2_reg;

    logic [31:0]        k_a;
    logic [62:0]        prod_a, prod_b;
    logic [62:0]        rnd_a, rnd_b;
    logic signed [TW-1:0] term_a_next, term_b_next;
    logic signed [TW-1:0] term_a_reg, term_b_reg;

    logic [31:0]        k_base;
    logic signed [TW-1:0] acc;
    logic [31:0]        w_clamped;
    logic [31:0]        w_rnd;
    logic [31:0]        w_sh;
    logic [COEF_BITS-1:0] coef_next, coef_reg;

    assign phase2 = {req.phase[30:0], 1'b0};
    assign addr_a = cos_addr(req.phase);
    assign addr_b = cos_addr(phase2);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cos_a_reg  <= COS_TAB[addr_a];
            cos_b_reg  <= COS_TAB[addr_b];
            neg_a_reg  <= req.phase[31] ^ req.phase[30];
            neg_b_reg  <= phase2[31] ^ phase2[30];
            wtype1_reg <= req.wtype;
            unity1_reg <= req.unity;
        end
    end

    always_comb
    begin
        k_a    = (wtype1_reg == WIN_HAMMING) ? K_HAM_B : K_HALF;
        prod_a = 63'(k_a) * 63'(cos_a_reg);
        prod_b = 63'(K_BK_C) * 63'(cos_b_reg);
        rnd_a  = (prod_a + (63'(1) << 29)) >> 30;
        rnd_b  = (prod_b + (63'(1) << 29)) >> 30;
        // term_a is minus the signed product, term_b the signed product
        term_a_next = neg_a_reg ? $signed(TW'(rnd_a[31:0])) : -$signed(TW'(rnd_a[31:0]));
        term_b_next = neg_b_reg ? -$signed(TW'(rnd_b[31:0])) : $signed(TW'(rnd_b[31:0]));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            term_a_reg <= term_a_next;
            term_b_reg <= term_b_next;
            wtype2_reg <= wtype1_reg;
            unity2_reg <= unity1_reg;
        end
    end

    always_comb
    begin
        case (wtype2_reg)
            WIN_HAMMING:  k_base = K_HAM_A;
            WIN_HANN:     k_base = K_HALF;
            WIN_BLACKMAN: k_base = K_BK_A;
            default:      k_base = '0;
        endcase
        acc = $signed(TW'(k_base)) + term_a_reg
            + ((wtype2_reg == WIN_BLACKMAN) ? term_b_reg : TW'(0));
        if (acc < 0)
            w_clamped = '0;
        else if (acc > $signed(TW'(ONE_Q30)))
            w_clamped = ONE_Q30;
        else
            w_clamped = acc[31:0];
        w_rnd = w_clamped + (32'(1) << (30 - COEF_BITS));
        w_sh  = w_rnd >> (31 - COEF_BITS);
        if (unity2_reg || (wtype2_reg == WIN_RECT))
            coef_next = COEF_BITS'(1) << (COEF_BITS - 1);
        else
            coef_next = w_sh[COEF_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            coef_reg <= coef_next;
    end

    assign coef = coef_reg;

endmodule

`default_nettype wire

>>> src/spectral_window_multiplier.sv
// Spectral window multiplier, top level.
// Depends on swm_pkg, swm_if, swm_step_div and swm_coef_unit.
//
// Usage:
//   samples : sink of signed sample words, valid/ready.
//   results : source of windowed_sample, coefficient and frame_end words.
//   cfg_we/cfg_index/cfg_wdata: register writes, index 0 frame_length,
//   index 1 window_type, other indexes ignored. Write only while idle.
// Timing:
//   One sample word per cycle while not stalled and no divide runs. A result
//   word is valid on results after these registered steps: cosine ROM read
//   at the accepting edge, then constant products, coefficient sum, sample
//   product, round and saturate. A frame_length write restarts the frame
//   and runs the phase step divider; samples.ready is low after the write
//   until the divider is done (no division for lengths of 0 or 1).
// Reset: frame length 1024 (capped at MAX_FRAME), rectangular window,
//   position 0, phase step preset, pipeline empty.
// Stall: when results.ready is low with a word held, the whole pipeline
//   holds and samples.ready drops; no word is lost or repeated.
`default_nettype none

module spectral_window_multiplier
    import swm_pkg::*;
#(
    parameter int MAX_FRAME       = 4096,
    parameter int SAMPLE_BITS     = 16,
    parameter int COEF_BITS       = 16,
    parameter int COS_TABLE_DEPTH = 1024
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    swm_sample_if.sink             samples,
    swm_result_if.source           results
);

    localparam int PW  = $clog2(MAX_FRAME);
    localparam int NW  = PW + 1;
    localparam int PRW = SAMPLE_BITS + COEF_BITS + 1;
    localparam int SH  = COEF_BITS - 1;

    localparam int RST_N = (RST_FRAME_LENGTH < MAX_FRAME) ? RST_FRAME_LENGTH : MAX_FRAME;
    localparam logic [63:0] RST_STEP64 =
        ((64'd1 << 32) + 64'((RST_N - 1) / 2)) / 64'(RST_N - 1);
    localparam logic [31:0] RST_STEP = RST_STEP64[31:0];

    localparam logic signed [PRW-1:0] S_MAX =
        PRW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [PRW-1:0] S_MIN = ~S_MAX;

    logic [NW-1:0]      n_reg, n_next;
    logic [WTYPE_W-1:0] wtype_reg, wtype_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic [31:0]        phase_reg, phase_next;
    logic [31:0]        step_reg, step_next;

    logic               adv;
    logic               accept;
    logic               frame_wr;
    logic [NW-1:0]      n_new;
    logic [NW-1:0]      dvsr;
    logic               div_start;
    div_status_t        div_st;
    logic [31:0]        div_q;
    logic               last;
    coef_req_t          req;
    logic [COEF_BITS-1:0] coef;

    logic [3:0]         vld_reg, vld_next;
    logic               out_vld_reg;
    logic signed [SAMPLE_BITS-1:0] samp1_reg, samp2_reg, samp3_reg;
    logic               last1_reg, last2_reg, last3_reg, last4_reg;
    logic [COEF_BITS-1:0] coef4_reg;
    logic signed [PRW-1:0] prod_next, prod_reg;
    logic signed [PRW-1:0] q, r;
    logic signed [SAMPLE_BITS-1:0] ws_next, ws_reg;
    logic [COEF_BITS-1:0] coef_out_reg;
    logic               end_out_reg;

    assign adv           = !out_vld_reg || results.ready;
    assign samples.ready = adv && !div_st.busy && !div_st.done;
    assign accept        = samples.valid && samples.ready;
    assign frame_wr      = cfg_we && (cfg_index == REG_FRAME_LENGTH);

    always_comb
    begin
        if (cfg_wdata == '0)
            n_new = NW'(1);
        else if (32'(cfg_wdata) > 32'(MAX_FRAME))
            n_new = NW'(MAX_FRAME);
        else
            n_new = NW'(cfg_wdata);
        dvsr      = n_new - NW'(1);
        div_start = frame_wr && (n_new >= NW'(2));
    end

    swm_step_div #(
        .DIV_W (PW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (dvsr[PW-1:0]),
        .status   (div_st),
        .quotient (div_q)
    );

    assign last      = (NW'(pos_reg) + NW'(1)) == n_reg;
    assign req.phase = last ? '0 : phase_reg;
    assign req.wtype = wtype_reg;
    assign req.unity = n_reg < NW'(2);

    always_comb
    begin
        n_next     = n_reg;
        wtype_next = wtype_reg;
        pos_next   = pos_reg;
        phase_next = phase_reg;
        step_next  = step_reg;
        if (div_st.done)
            step_next = div_q;
        if (cfg_we && (cfg_index == REG_WINDOW_TYPE))
            wtype_next = cfg_wdata[WTYPE_W-1:0];
        if (frame_wr)
        begin
            n_next     = n_new;
            pos_next   = '0;
            phase_next = '0;
            if (n_new < NW'(2))
                step_next = '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                pos_next   = '0;
                phase_next = '0;
            end
            else
            begin
                pos_next   = pos_reg + PW'(1);
                phase_next = phase_reg + step_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg     <= NW'(RST_N);
            wtype_reg <= WIN_RECT;
            pos_reg   <= '0;
            phase_reg <= '0;
            step_reg  <= RST_STEP;
        end
        else
        begin
            n_reg     <= n_next;
            wtype_reg <= wtype_next;
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            step_reg  <= step_next;
        end
    end

    swm_coef_unit #(
        .COEF_BITS       (COEF_BITS),
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_coef (
        .clk  (clk),
        .adv  (adv),
        .req  (req),
        .coef (coef)
    );

    assign vld_next = {vld_reg[2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= vld_next;
            out_vld_reg <= vld_reg[3];
        end
    end

    always_comb
    begin
        prod_next = PRW'(samp3_reg) * $signed(PRW'(coef));
        q         = prod_reg + $signed(PRW'(1) << (SH - 1));
        r         = q >>> SH;
        if (r > S_MAX)
            ws_next = S_MAX[SAMPLE_BITS-1:0];
        else if (r < S_MIN)
            ws_next = S_MIN[SAMPLE_BITS-1:0];
        else
            ws_next = r[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            samp1_reg    <= samples.sample;
            samp2_reg    <= samp1_reg;
            samp3_reg    <= samp2_reg;
            last1_reg    <= last;
            last2_reg    <= last1_reg;
            last3_reg    <= last2_reg;
            last4_reg    <= last3_reg;
            coef4_reg    <= coef;
            prod_reg     <= prod_next;
            ws_reg       <= ws_next;
            coef_out_reg <= coef4_reg;
            end_out_reg  <= last4_reg;
        end
    end

    assign results.valid           = out_vld_reg;
    assign results.windowed_sample = ws_reg;
    assign results.coefficient     = coef_out_reg;
    assign results.frame_end       = end_out_reg;

endmodule

`default_nettype wire
